// File: src/lsms_pkg.sv
package lsms_pkg;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lsms_state_t;

  // Operation kinds carried on the result channel
  typedef logic [2:0] op_kind_t;
  localparam op_kind_t K_LOAD    = 3'd0;
  localparam op_kind_t K_STORE   = 3'd1;
  localparam op_kind_t K_WB      = 3'd2;
  localparam op_kind_t K_LOADPC  = 3'd3;
  localparam op_kind_t K_STOREPC = 3'd4;
  localparam op_kind_t K_NONE    = 3'd5;

  // Branch hints on a load of the pc
  typedef logic [1:0] hint_t;
  localparam hint_t HINT_NONE = 2'd0;
  localparam hint_t HINT_RSB  = 2'd1;
  localparam hint_t HINT_FAST = 2'd2;

  localparam logic [3:0]  SP_REG    = 4'd13;
  localparam logic [3:0]  PC_REG    = 4'd15;
  localparam logic [31:0] WORD_STEP = 32'd4;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 72;

endpackage

// File: src/load_store_multiple_sequencer.sv
// Load/store-multiple sequencer. Takes one LDM/STM instruction per input item
// and emits its operations, one result item per cycle while the receiver keeps
// up. The low registers set in the list come first, in ascending order; their
// addresses start at the first address of the item, step by 4 and wrap at 2^32.
// Then comes the base writeback: for a load only when the base is not in the
// list, for a store whenever writeback is set. Then comes the r15 transfer,
// which takes the next address of the run. A load of r15 sets block_end and a
// hint: return-stack pop when the base is r13, fast dispatch otherwise. An
// instruction that causes nothing emits a single none item. tlast marks the
// final item of each run. An instruction is captured in the idle state and
// causes at least one and at most 17 operations. The single priority encoder
// and address adder pick and place one register per cycle. The input is not
// ready while a run is in progress. The output register lets the next
// instruction be captured while the final item of the previous one still waits.
module load_store_multiple_sequencer #(
  parameter int LOW_REG_COUNT = 15   // registers 0..LOW_REG_COUNT-1 transferred, 8 to 15
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // base_reg[3:0], reg_list[19:4], first_addr[51:20],
  // wb_value[83:52], pc_value[115:84], zero pad[119:116]
  input  logic [lsms_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[0], writeback[1]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // reg_index[3:0], address[35:4], value[67:36], block_end[68], hint[70:69],
  // zero pad[71]
  output logic [lsms_pkg::OUT_TDATA_W-1:0] out_tdata,
  // op_kind[2:0]
  output logic [2:0]                       out_tuser,
  output logic                             out_tlast
);
  import lsms_pkg::*;

  localparam int RW = LOW_REG_COUNT;

  // Sequencer state
  lsms_state_t    state_r, state_nxt;
  logic [RW-1:0]  rem_r, rem_nxt;        // low registers still to transfer
  logic           wb_pend_r, wb_pend_nxt;
  logic           pc_pend_r, pc_pend_nxt;
  logic           store_r, store_nxt;
  logic [3:0]     base_r, base_nxt;
  logic [31:0]    addr_r, addr_nxt;
  logic [31:0]    wbaddr_r, wbaddr_nxt;
  logic [31:0]    pc_r, pc_nxt;

  // Output register
  logic           ovld_r, ovld_nxt;
  op_kind_t       okind_r, okind_nxt;
  logic [3:0]     oreg_r, oreg_nxt;
  logic [31:0]    oaddr_r, oaddr_nxt;
  logic [31:0]    oval_r, oval_nxt;
  logic           obend_r, obend_nxt;
  hint_t          ohint_r, ohint_nxt;
  logic           olast_r, olast_nxt;

  // Step logic
  logic           slot_free;
  logic [3:0]     low_idx;
  logic [RW-1:0]  rem_clr;
  logic [15:0]    in_list;

  assign slot_free = !ovld_r || out_tready;
  assign rem_clr   = rem_r & (rem_r - {{(RW-1){1'b0}}, 1'b1});
  assign in_list   = in_tdata[19:4];

  // Lowest set register of those remaining
  always_comb begin
    low_idx = 4'd0;
    for (int i = RW - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        low_idx = 4'(i);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rem_nxt     = rem_r;
    wb_pend_nxt = wb_pend_r;
    pc_pend_nxt = pc_pend_r;
    store_nxt   = store_r;
    base_nxt    = base_r;
    addr_nxt    = addr_r;
    wbaddr_nxt  = wbaddr_r;
    pc_nxt      = pc_r;
    ovld_nxt    = ovld_r && !out_tready;
    okind_nxt   = okind_r;
    oreg_nxt    = oreg_r;
    oaddr_nxt   = oaddr_r;
    oval_nxt    = oval_r;
    obend_nxt   = obend_r;
    ohint_nxt   = ohint_r;
    olast_nxt   = olast_r;
    in_tready   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          store_nxt   = in_tuser[0];
          base_nxt    = in_tdata[3:0];
          rem_nxt     = in_list[RW-1:0];
          wb_pend_nxt = in_tuser[1] && (in_tuser[0] || !in_list[in_tdata[3:0]]);
          pc_pend_nxt = in_list[15];
          addr_nxt    = in_tdata[51:20];
          wbaddr_nxt  = in_tdata[83:52];
          pc_nxt      = in_tdata[115:84];
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          ovld_nxt  = 1'b1;
          oaddr_nxt = 32'd0;
          oval_nxt  = 32'd0;
          obend_nxt = 1'b0;
          ohint_nxt = HINT_NONE;
          if (rem_r != '0) begin
            okind_nxt = store_r ? K_STORE : K_LOAD;
            oreg_nxt  = low_idx;
            oaddr_nxt = addr_r;
            olast_nxt = (rem_clr == '0) && !wb_pend_r && !pc_pend_r;
            rem_nxt   = rem_clr;
            addr_nxt  = addr_r + WORD_STEP;
          end else if (wb_pend_r) begin
            okind_nxt   = K_WB;
            oreg_nxt    = base_r;
            oval_nxt    = wbaddr_r;
            olast_nxt   = !pc_pend_r;
            wb_pend_nxt = 1'b0;
          end else if (pc_pend_r) begin
            oreg_nxt    = PC_REG;
            oaddr_nxt   = addr_r;
            olast_nxt   = 1'b1;
            pc_pend_nxt = 1'b0;
            if (store_r) begin
              okind_nxt = K_STOREPC;
              oval_nxt  = pc_r;
            end else begin
              okind_nxt = K_LOADPC;
              obend_nxt = 1'b1;
              ohint_nxt = (base_r == SP_REG) ? HINT_RSB : HINT_FAST;
            end
          end else begin
            // nothing to do at all: a single none item
            okind_nxt = K_NONE;
            oreg_nxt  = 4'd0;
            olast_nxt = 1'b1;
          end
          if (olast_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ovld_r    <= 1'b0;
      rem_r     <= '0;
      wb_pend_r <= 1'b0;
      pc_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ovld_r    <= ovld_nxt;
      rem_r     <= rem_nxt;
      wb_pend_r <= wb_pend_nxt;
      pc_pend_r <= pc_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r  <= store_nxt;
    base_r   <= base_nxt;
    addr_r   <= addr_nxt;
    wbaddr_r <= wbaddr_nxt;
    pc_r     <= pc_nxt;
    okind_r  <= okind_nxt;
    oreg_r   <= oreg_nxt;
    oaddr_r  <= oaddr_nxt;
    oval_r   <= oval_nxt;
    obend_r  <= obend_nxt;
    ohint_r  <= ohint_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {1'b0, ohint_r, obend_r, oval_r, oaddr_r, oreg_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  // An accepted instruction always starts a run
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_RUN))
    else $error("accepted item did not start a run");

  // Emitting the final item of a run returns to idle
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && slot_free && olast_nxt) |=> (state_r == ST_IDLE))
    else $error("run did not end after its final item");

  // The remaining list only loses bits within a run
  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && $past(state_r) == ST_RUN) |-> ((rem_r & ~$past(rem_r)) == '0))
    else $error("register list gained bits mid-run");

  // block_end goes with a load of the pc, and a hint only with block_end
  a_bend_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> ((obend_r == (okind_r == K_LOADPC)) && (obend_r || ohint_r == HINT_NONE)))
    else $error("block_end or hint on the wrong item");

  // A none item only ever stands alone
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && okind_r == K_NONE) |-> olast_r)
    else $error("none item not marked last");

endmodule

// File: bench/load_store_multiple_sequencer_checker.sv
`timescale 1ns / 1ps

// Watches both channels, expands each accepted instruction into the operations
// it should cause and compares every result item against the oldest one due.
module load_store_multiple_sequencer_checker #(
  parameter int LOW_REG_COUNT = 15
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [lsms_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]                       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [lsms_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [2:0]                       out_tuser,
  input  logic                             out_tlast,
  output int                               fail_count,
  output int                               pending_count,
  output int                               instr_count,
  output int                               op_count
);
  import lsms_pkg::*;

  typedef struct packed {
    op_kind_t    kind;
    logic [3:0]  reg_index;
    logic [31:0] address;
    logic [31:0] value;
    logic        block_end;
    hint_t       hint;
    logic        last;
  } lsm_op_t;

  lsm_op_t ops_due[$];
  int      errs = 0;
  int      n_instr = 0;
  int      n_ops = 0;

  function automatic lsm_op_t make_op(input op_kind_t kind, input logic [3:0] idx,
                                      input logic [31:0] addr, input logic [31:0] val,
                                      input logic bend, input hint_t hint);
    lsm_op_t op;
    op.kind      = kind;
    op.reg_index = idx;
    op.address   = addr;
    op.value     = val;
    op.block_end = bend;
    op.hint      = hint;
    op.last      = 1'b0;
    return op;
  endfunction

  // Expands one LDM/STM into its run of operations and queues them.
  function automatic void expand_instr(input logic store, input logic wb,
                                       input logic [3:0] base, input logic [15:0] list,
                                       input logic [31:0] start, input logic [31:0] wb_addr,
                                       input logic [31:0] pc);
    lsm_op_t     run [17];
    int          n;
    int          r;
    logic [31:0] addr;
    n    = 0;
    addr = start;
    for (r = 0; r < LOW_REG_COUNT && r < 15; r++) begin
      if (list[r]) begin
        run[n] = make_op(store ? K_STORE : K_LOAD, 4'(r), addr, 32'd0, 1'b0, HINT_NONE);
        n++;
        addr = addr + WORD_STEP;
      end
    end
    // load: writeback only when base not reloaded; store: always
    if (wb && (store || !list[base])) begin
      run[n] = make_op(K_WB, base, 32'd0, wb_addr, 1'b0, HINT_NONE);
      n++;
    end
    if (list[PC_REG]) begin
      if (store) begin
        run[n] = make_op(K_STOREPC, PC_REG, addr, pc, 1'b0, HINT_NONE);
      end else begin
        run[n] = make_op(K_LOADPC, PC_REG, addr, 32'd0, 1'b1,
                         (base == SP_REG) ? HINT_RSB : HINT_FAST);
      end
      n++;
    end
    if (n == 0) begin
      run[0] = make_op(K_NONE, 4'd0, 32'd0, 32'd0, 1'b0, HINT_NONE);
      n = 1;
    end
    run[n-1].last = 1'b1;
    for (r = 0; r < n; r++) ops_due.push_back(run[r]);
  endfunction

  task automatic check_op(input lsm_op_t want, input lsm_op_t got);
    if (got.kind !== want.kind) begin
      $error("op_kind mismatch: expected %0d, got %0d", want.kind, got.kind);
      errs++;
    end
    if (got.reg_index !== want.reg_index) begin
      $error("reg_index mismatch: expected %0d, got %0d", want.reg_index, got.reg_index);
      errs++;
    end
    if (got.address !== want.address) begin
      $error("address mismatch: expected %h, got %h", want.address, got.address);
      errs++;
    end
    if (got.value !== want.value) begin
      $error("value mismatch: expected %h, got %h", want.value, got.value);
      errs++;
    end
    if (got.block_end !== want.block_end) begin
      $error("block_end mismatch: expected %0d, got %0d", want.block_end, got.block_end);
      errs++;
    end
    if (got.hint !== want.hint) begin
      $error("hint mismatch: expected %0d, got %0d", want.hint, got.hint);
      errs++;
    end
    if (got.last !== want.last) begin
      $error("last mismatch: expected %0d, got %0d", want.last, got.last);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    lsm_op_t seen;
    lsm_op_t due;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.kind      = out_tuser;
        seen.reg_index = out_tdata[3:0];
        seen.address   = out_tdata[35:4];
        seen.value     = out_tdata[67:36];
        seen.block_end = out_tdata[68];
        seen.hint      = out_tdata[70:69];
        seen.last      = out_tlast;
        n_ops++;
        if (ops_due.size() == 0) begin
          $error("unexpected item: op_kind %0d reg_index %0d address %h",
                 seen.kind, seen.reg_index, seen.address);
          errs++;
        end else begin
          due = ops_due.pop_front();
          check_op(due, seen);
        end
      end
      if (in_tvalid && in_tready) begin
        expand_instr(in_tuser[0], in_tuser[1], in_tdata[3:0], in_tdata[19:4],
                     in_tdata[51:20], in_tdata[83:52], in_tdata[115:84]);
        n_instr++;
      end
    end
    fail_count    <= errs;
    pending_count <= ops_due.size();
    instr_count   <= n_instr;
    op_count      <= n_ops;
  end

endmodule

// File: bench/load_store_multiple_sequencer_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the LDM/STM sequencer; the checker does all of the
// prediction and comparison.
module load_store_multiple_sequencer_test;
  import lsms_pkg::*;

  localparam int   LOW_REGS     = 15;
  localparam int   RANDOM_ITEMS = 380;
  localparam int   HOLD_CYCLES  = 150;     // long receiver hold-off
  localparam int   DRAIN_CYCLES = 24;      // quiet tail after the last result
  // Sized for the worst item: 17 results, each after the longest stall, plus the
  // longest gap; ~400 items plus two hold-offs, then several times over.
  localparam int   CYCLE_LIMIT  = 300000;
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_STORE   = 1'b1;
  localparam logic WB_OFF       = 1'b0;
  localparam logic WB_ON        = 1'b1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   out_tlast;

  // When set, neither side idles: back-to-back items on both channels
  logic steady = 1'b0;

  int fail_count;
  int pending_count;
  int instr_count;
  int op_count;
  int cycle_count = 0;

  always #6 clk = ~clk;

  load_store_multiple_sequencer #(
    .LOW_REG_COUNT(LOW_REGS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  load_store_multiple_sequencer_checker #(
    .LOW_REG_COUNT(LOW_REGS)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .instr_count  (instr_count),
    .op_count     (op_count)
  );

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("load_store_multiple_sequencer_test failed");
      $finish;
    end
  end

  // Offers one instruction after a random gap and returns at the edge where it
  // is taken. Valid is left high so a zero gap gives back-to-back items.
  task automatic offer_instr(input logic mode, input logic wb, input logic [3:0] base,
                             input logic [15:0] list, input logic [31:0] start,
                             input logic [31:0] wb_addr, input logic [31:0] pc);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // pad, pc_value, wb_value, first_addr, reg_list, base_reg
    in_tdata  <= {4'b0, pc, wb_addr, start, list, base};
    in_tuser  <= {wb, mode};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random instruction. Lists lean towards the interesting shapes: empty, full,
  // a single register, sparse; the base is often put in the list so that the
  // suppressed load writeback turns up, and start addresses often sit just
  // below the top of memory so the address run wraps.
  task automatic offer_random();
    logic [15:0] list;
    logic [31:0] start;
    logic [3:0]  base;
    int          pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        list = 16'h0000;
      end
      1: begin
        list = 16'hFFFF;
      end
      2: begin
        list = 16'h0001 << $urandom_range(0, 15);
      end
      3: begin
        list = 16'($urandom) & 16'($urandom) & 16'($urandom);
      end
      default: begin
        list = 16'($urandom);
      end
    endcase
    base = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 3) == 0) list[base] = 1'b1;
    if ($urandom_range(0, 4) == 0) start = 32'hFFFF_FFFF - 32'($urandom_range(0, 63));
    else start = $urandom;
    offer_instr(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), base, list, start,
                $urandom, $urandom);
  endtask

  // Receiver: random stall before each item, two long hold-offs so the block
  // backs up and drops in_tready while the sender keeps offering.
  initial begin
    int taken;
    int stall;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 40 || taken == 1500) stall = HOLD_CYCLES;
      else if (steady) stall = 0;
      else stall = $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part
    // empty runs, load and store
    offer_instr(MODE_LOAD,  WB_OFF, 4'd0,  16'h0000, 32'h0000_0000, 32'h0, 32'h0);
    offer_instr(MODE_STORE, WB_OFF, 4'd15, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
    // full lists, address run wrapping past the top; load base in list
    offer_instr(MODE_LOAD,  WB_ON,  4'd0,  16'hFFFF, 32'hFFFF_FFF8, 32'h1234_5678,
                32'h0);
    offer_instr(MODE_STORE, WB_ON,  4'd5,  16'hFFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
    // loads of the pc: return-stack hint via r13, fast dispatch otherwise
    offer_instr(MODE_LOAD,  WB_OFF, SP_REG, 16'h8000, 32'h0000_1000, 32'h0, 32'h0);
    offer_instr(MODE_LOAD,  WB_ON,  SP_REG, 16'h8000, 32'h0000_2000, 32'h0000_2004,
                32'h0);
    offer_instr(MODE_LOAD,  WB_OFF, 4'd7,  16'hC000, 32'hFFFF_FFFC, 32'h0, 32'h0);
    // base r15 on a load with writeback: suppressed when bit 15 set, kept if not
    offer_instr(MODE_LOAD,  WB_ON,  PC_REG, 16'h8000, 32'h0000_0040, 32'hDEAD_BEEF,
                32'h0);
    offer_instr(MODE_LOAD,  WB_ON,  PC_REG, 16'h0001, 32'h0000_0040, 32'hDEAD_BEEF,
                32'h0);
    // writeback only, load and store
    offer_instr(MODE_STORE, WB_ON,  4'd3,  16'h0000, 32'h0, 32'h0000_0010, 32'h0);
    offer_instr(MODE_LOAD,  WB_ON,  4'd3,  16'h0000, 32'h0, 32'h0000_0020, 32'h0);
    // base in list: load drops the writeback, store keeps it
    offer_instr(MODE_LOAD,  WB_ON,  4'd3,  16'h0008, 32'h0000_0100, 32'h0000_0104,
                32'h0);
    offer_instr(MODE_STORE, WB_ON,  4'd3,  16'h0008, 32'h0000_0100, 32'h0000_0104,
                32'h0);
    // store of the pc after a base writeback with base r15
    offer_instr(MODE_STORE, WB_ON,  PC_REG, 16'h8000, 32'h8000_0000, 32'h8000_0004,
                32'h0000_8008);
    // r14 alone, at the very top of memory
    offer_instr(MODE_LOAD,  WB_OFF, 4'd1,  16'h4000, 32'hFFFF_FFFC, 32'h0, 32'h0);
    // alternating bit patterns so every field bit sees both values
    offer_instr(MODE_STORE, WB_ON,  4'd10, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA);
    offer_instr(MODE_LOAD,  WB_ON,  4'd5,  16'h5555, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555);
    offer_instr(MODE_STORE, WB_OFF, 4'd0,  16'h0001, 32'h0000_0000, 32'h0, 32'h0);
    offer_instr(MODE_LOAD,  WB_OFF, 4'd15, 16'h7FFF, 32'h0000_0003, 32'h0, 32'h0);

    // Random part; every fourth block of 32 runs with no idling on either side
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      steady = ((k / 32) % 4 == 3);
      offer_random();
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // Drain: let the last item's expectations land, then wait
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d LDM/STM items through the sequencer, %0d operations compared,",
             instr_count, op_count);
    $display("covering empty, full and wrapping lists, writeback rules and pc hints.");
    if (fail_count == 0) begin
      $display("load_store_multiple_sequencer_test passed");
    end else begin
      $display("load_store_multiple_sequencer_test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lsms_pkg.sv
src/load_store_multiple_sequencer.sv
bench/load_store_multiple_sequencer_checker.sv
bench/load_store_multiple_sequencer_test.sv
